// ----- src/qrs_pkg.sv -----
package qrs_pkg;

    localparam int SqrtSteps = 32;
    localparam int DivSteps  = 34;

    typedef enum logic [1:0] {
        STATUS_NONE   = 2'd0,
        STATUS_DOUBLE = 2'd1,
        STATUS_TWO    = 2'd2,
        STATUS_AZERO  = 2'd3
    } status_t;

    // One square-root cell slot: sideband plus radicand, remainder, root
    typedef struct packed {
        logic               vld;
        logic signed [33:0] disc;
        status_t            status;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic [63:0]        rad;
        logic [34:0]        rem;
        logic [31:0]        root;
    } sq_t;

    // One divider cell slot: two lanes sharing the divisor
    typedef struct packed {
        logic               vld;
        logic signed [33:0] disc;
        status_t            status;
        logic [15:0]        den;
        logic               neg1;
        logic               neg2;
        logic [33:0]        q1;
        logic [15:0]        r1;
        logic [33:0]        q2;
        logic [15:0]        r2;
    } dv_t;

endpackage

// ----- src/qrs_coef_if.sv -----
interface qrs_coef_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

// ----- src/qrs_root_if.sv -----
interface qrs_root_if;
    logic               valid;
    logic               ready;
    logic signed [33:0] disc_value;
    logic [1:0]         root_status;
    logic signed [31:0] first_root;
    logic signed [31:0] second_root;

    modport source (output valid, output disc_value, output root_status,
                    output first_root, output second_root, input ready);
    modport sink   (input valid, input disc_value, input root_status,
                    input first_root, input second_root, output ready);
endinterface

// ----- src/qrs_sqrt_cell.sv -----
module qrs_sqrt_cell (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  qrs_pkg::sq_t cell_in,
    output qrs_pkg::sq_t cell_out
);
    import qrs_pkg::*;

    sq_t         cell_reg;
    sq_t         cell_next;
    logic [34:0] rem_sh;
    logic [34:0] trial;

    // One restoring step: two radicand bits in, one root bit out
    always_comb
    begin
        rem_sh    = {cell_in.rem[32:0], cell_in.rad[63:62]};
        trial     = {1'b0, cell_in.root, 2'b01};
        cell_next = cell_in;
        cell_next.rad = {cell_in.rad[61:0], 2'b00};
        if (rem_sh >= trial)
        begin
            cell_next.rem  = rem_sh - trial;
            cell_next.root = {cell_in.root[30:0], 1'b1};
        end
        else
        begin
            cell_next.rem  = rem_sh;
            cell_next.root = {cell_in.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else if (adv)
            cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;
endmodule

// ----- src/qrs_div_cell.sv -----
module qrs_div_cell (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  qrs_pkg::dv_t cell_in,
    output qrs_pkg::dv_t cell_out
);
    import qrs_pkg::*;

    dv_t         cell_reg;
    dv_t         cell_next;
    logic [16:0] sh1;
    logic [16:0] sh2;

    // One restoring divide step on both lanes
    always_comb
    begin
        sh1       = {cell_in.r1, cell_in.q1[33]};
        sh2       = {cell_in.r2, cell_in.q2[33]};
        cell_next = cell_in;
        if (sh1 >= {1'b0, cell_in.den})
        begin
            cell_next.r1 = 16'(sh1 - {1'b0, cell_in.den});
            cell_next.q1 = {cell_in.q1[32:0], 1'b1};
        end
        else
        begin
            cell_next.r1 = sh1[15:0];
            cell_next.q1 = {cell_in.q1[32:0], 1'b0};
        end
        if (sh2 >= {1'b0, cell_in.den})
        begin
            cell_next.r2 = 16'(sh2 - {1'b0, cell_in.den});
            cell_next.q2 = {cell_in.q2[32:0], 1'b1};
        end
        else
        begin
            cell_next.r2 = sh2[15:0];
            cell_next.q2 = {cell_in.q2[32:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else if (adv)
            cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;
endmodule

// ----- src/quadratic_root_solver.sv -----
// Pipeline from request accept to result valid: 1 multiply stage,
// 32 square-root cells, 1 numerator stage, 34 divider cells, 1 output stage.
// Throughput: one request per cycle; the whole cell chain holds while the
// output register carries a result that is not taken.
// Reset: rst_n is asynchronous active low and clears every valid flag.
module quadratic_root_solver (
    input  logic            clk,
    input  logic            rst_n,
    qrs_coef_if.sink        coef_in,
    qrs_root_if.source      root_out
);
    import qrs_pkg::*;

    logic adv;

    // Stage 1: products
    logic               s1_vld_reg;
    logic signed [31:0] s1_bb_reg;
    logic signed [31:0] s1_ac_reg;
    logic signed [15:0] s1_a_reg;
    logic signed [15:0] s1_b_reg;

    logic signed [33:0] disc;
    status_t            status;
    sq_t                sq_chain [SqrtSteps+1];
    dv_t                dv_chain [DivSteps+1];
    dv_t                dv_first_reg;
    dv_t                dv_first_next;

    logic signed [34:0] nb;
    logic signed [34:0] num1;
    logic signed [34:0] num2;
    logic signed [34:0] abs1;
    logic signed [34:0] abs2;

    logic               out_vld_reg;
    logic signed [33:0] out_disc_reg;
    status_t            out_status_reg;
    logic signed [31:0] out_r1_reg;
    logic signed [31:0] out_r2_reg;
    logic signed [31:0] r1_next;
    logic signed [31:0] r2_next;

    function automatic logic signed [31:0] sat_root(input logic [33:0] q, input logic neg);
        logic signed [31:0] res;
        if (neg)
        begin
            if (q > 34'h080000000)
                res = 32'sh80000000;
            else
                res = 32'(-$signed({1'b0, q}));
        end
        else
        begin
            if (q > 34'h07FFFFFFF)
                res = 32'sh7FFFFFFF;
            else
                res = q[31:0];
        end
        return res;
    endfunction

    assign adv           = !out_vld_reg || root_out.ready;
    assign coef_in.ready = adv;

    // Multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= coef_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_bb_reg <= coef_in.coef_b * coef_in.coef_b;
            s1_ac_reg <= coef_in.coef_a * coef_in.coef_c;
            s1_a_reg  <= coef_in.coef_a;
            s1_b_reg  <= coef_in.coef_b;
        end
    end

    // Discriminant and status, feeding the first square-root cell
    always_comb
    begin
        disc = 34'(s1_bb_reg) - (34'(s1_ac_reg) <<< 2);
        if (s1_a_reg == '0)
            status = STATUS_AZERO;
        else if (disc < 0)
            status = STATUS_NONE;
        else if (disc == '0)
            status = STATUS_DOUBLE;
        else
            status = STATUS_TWO;
        sq_chain[0].vld    = s1_vld_reg;
        sq_chain[0].disc   = disc;
        sq_chain[0].status = status;
        sq_chain[0].a      = s1_a_reg;
        sq_chain[0].b      = s1_b_reg;
        sq_chain[0].rad    = disc[33] ? 64'd0 : {disc[33:0], 30'd0};
        sq_chain[0].rem    = '0;
        sq_chain[0].root   = '0;
    end

    for (genvar i = 0; i < SqrtSteps; i++)
    begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .cell_in  (sq_chain[i]),
            .cell_out (sq_chain[i+1])
        );
    end

    // Numerators and magnitudes for the divider
    always_comb
    begin
        nb   = -(35'(sq_chain[SqrtSteps].b) <<< 15);
        num1 = nb + $signed({3'b000, sq_chain[SqrtSteps].root});
        num2 = nb - $signed({3'b000, sq_chain[SqrtSteps].root});
        abs1 = num1[34] ? -num1 : num1;
        abs2 = num2[34] ? -num2 : num2;
        dv_first_next.vld    = sq_chain[SqrtSteps].vld;
        dv_first_next.disc   = sq_chain[SqrtSteps].disc;
        dv_first_next.status = sq_chain[SqrtSteps].status;
        dv_first_next.den    = sq_chain[SqrtSteps].a[15] ? 16'(-sq_chain[SqrtSteps].a)
                                                         : sq_chain[SqrtSteps].a;
        dv_first_next.neg1   = num1[34] ^ sq_chain[SqrtSteps].a[15];
        dv_first_next.neg2   = num2[34] ^ sq_chain[SqrtSteps].a[15];
        dv_first_next.q1     = abs1[33:0];
        dv_first_next.r1     = '0;
        dv_first_next.q2     = abs2[33:0];
        dv_first_next.r2     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_first_reg <= '0;
        else if (adv)
            dv_first_reg <= dv_first_next;
    end

    assign dv_chain[0] = dv_first_reg;

    for (genvar j = 0; j < DivSteps; j++)
    begin : g_div
        qrs_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .cell_in  (dv_chain[j]),
            .cell_out (dv_chain[j+1])
        );
    end

    // Saturate and mask roots by status
    always_comb
    begin
        r1_next = '0;
        r2_next = '0;
        case (dv_chain[DivSteps].status)
            STATUS_DOUBLE:
            begin
                r1_next = sat_root(dv_chain[DivSteps].q1, dv_chain[DivSteps].neg1);
            end
            STATUS_TWO:
            begin
                r1_next = sat_root(dv_chain[DivSteps].q1, dv_chain[DivSteps].neg1);
                r2_next = sat_root(dv_chain[DivSteps].q2, dv_chain[DivSteps].neg2);
            end
            default:
            begin
                r1_next = '0;
                r2_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= dv_chain[DivSteps].vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_disc_reg   <= dv_chain[DivSteps].disc;
            out_status_reg <= dv_chain[DivSteps].status;
            out_r1_reg     <= r1_next;
            out_r2_reg     <= r2_next;
        end
    end

    assign root_out.valid       = out_vld_reg;
    assign root_out.disc_value  = out_disc_reg;
    assign root_out.root_status = out_status_reg;
    assign root_out.first_root  = out_r1_reg;
    assign root_out.second_root = out_r2_reg;

    // No-root and a-zero results carry zero roots
    a_noroot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (out_status_reg == STATUS_NONE || out_status_reg == STATUS_AZERO)
        |-> out_r1_reg == '0 && out_r2_reg == '0)
        else $error("root nonzero without roots");

    a_double_second: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_status_reg == STATUS_DOUBLE |-> out_r2_reg == '0)
        else $error("second root nonzero on double root");

    a_neg_disc: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_disc_reg < 0
        |-> out_status_reg == STATUS_NONE || out_status_reg == STATUS_AZERO)
        else $error("negative discriminant with roots");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(dv_chain[DivSteps]) && $stable(out_r1_reg))
        else $error("pipeline moved during stall");
endmodule
